// ===== rtl/sjt_pkg.sv =====
// Shared types and constants for the SJT permutation generator.
// No dependencies; imported by sjt_cell, sjt_pick and the top level.
`default_nettype none

package sjt_pkg;

  // Fixed field widths of the ports
  localparam int SWAP_W      = 3;
  localparam int LABEL_OUT_W = 4;
  localparam int LEN_W       = 4;
  localparam int APB_DW      = 32;
  localparam int APB_AW      = 3;

  // Register indexes (byte address = 4 * index)
  typedef enum logic {
    REG_PERM_LENGTH = 1'b0
  } sjt_reg_t;

  localparam logic [LEN_W-1:0] PERM_LENGTH_RST = 4'd8;

  // Status a cell shows to its two neighbors
  typedef struct packed {
    logic dir;  // 0 = points left, 1 = points right
    logic hit;  // this cell holds the selected (largest mobile) label
  } sjt_stat_t;

endpackage

`default_nettype wire

// ===== rtl/sjt_cell.sv =====
// One position of the permutation row: label and direction bit.
// Depends on sjt_pkg; exchanges label and status with both neighbors.
`default_nettype none

module sjt_cell #(
  parameter int LW  = 4,
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic              step,
  input  logic              active,
  input  logic              left_ok,
  input  logic              right_ok,
  input  logic [LW-1:0]     left_label,
  input  logic [LW-1:0]     right_label,
  input  logic [LW-1:0]     sel_label,
  input  sjt_pkg::sjt_stat_t left_stat,
  input  sjt_pkg::sjt_stat_t right_stat,
  output logic [LW-1:0]     label,
  output sjt_pkg::sjt_stat_t stat,
  output logic              mobile
);
  import sjt_pkg::*;

  logic [LW-1:0] label_r, label_nxt;
  logic          dir_r, dir_nxt;
  logic [LW-1:0] nb_label, swap_label;
  logic          nb_ok, swap_dir, hit, flip;

  always_comb begin
    nb_label = dir_r ? right_label : left_label;
    nb_ok    = dir_r ? right_ok : left_ok;
    mobile   = active & nb_ok & (label_r > nb_label);
    hit      = (label_r == sel_label);

    // swap with the neighbor that the selected cell points at
    swap_label = label_r;
    swap_dir   = dir_r;
    if (hit) begin
      swap_label = dir_r ? right_label : left_label;
      swap_dir   = dir_r ? right_stat.dir : left_stat.dir;
    end else if (left_stat.hit && left_stat.dir) begin
      swap_label = left_label;
      swap_dir   = left_stat.dir;
    end else if (right_stat.hit && !right_stat.dir) begin
      swap_label = right_label;
      swap_dir   = right_stat.dir;
    end
    flip = active & (swap_label > sel_label);

    label_nxt = label_r;
    dir_nxt   = dir_r;
    if (load) begin
      label_nxt = LW'(IDX + 1);
      dir_nxt   = 1'b0;
    end else if (step) begin
      label_nxt = swap_label;
      dir_nxt   = swap_dir ^ flip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      label_r <= LW'(IDX + 1);
      dir_r   <= 1'b0;
    end else begin
      label_r <= label_nxt;
      dir_r   <= dir_nxt;
    end
  end

  assign label    = label_r;
  assign stat.dir = dir_r;
  assign stat.hit = hit;

endmodule

`default_nettype wire

// ===== rtl/sjt_pick.sv =====
// Picks the largest mobile label from the row of cells.
// Depends on sjt_pkg; labels are distinct, so a per-value flag vector suffices.
`default_nettype none

module sjt_pick #(
  parameter int N  = 8,
  parameter int LW = 4
) (
  input  logic [LW-1:0] labels [N],
  input  logic [N-1:0]  mobile,
  output logic          found,
  output logic [LW-1:0] sel_label
);
  import sjt_pkg::*;

  logic [N:1] seen;

  always_comb begin
    seen = '0;
    for (int v = 1; v <= N; v++) begin
      for (int i = 0; i < N; i++) begin
        if (mobile[i] && (labels[i] == LW'(v))) begin
          seen[v] = 1'b1;
        end
      end
    end
    sel_label = '0;
    for (int v = 1; v <= N; v++) begin
      if (seen[v]) begin
        sel_label = LW'(v);
      end
    end
    found = |seen;
  end

endmodule

`default_nettype wire

// ===== rtl/sjt_permutation_generator_core.sv =====
// Steinhaus-Johnson-Trotter permutation generator, top level.
// Depends on sjt_pkg, sjt_cell and sjt_pick.
//
// Usage:
//  - Input channel (in_valid/in_ready, in_restart): a transfer with
//    in_restart=1 reloads labels 1..MAX_ELEMENTS, all pointing left; with
//    in_restart=0 it advances one step of the Gray-like transposition order.
//  - Result channel (out_valid/out_ready): one transfer per input transfer,
//    carrying the left position of the swapped pair, the moved label, or
//    out_finished=1 when no label is mobile (state unchanged then); all zero on restart.
//  - APB register 0 (byte address 0): perm_length, 4 bits, reset 8. Zero
//    acts as 1, values above MAX_ELEMENTS act as MAX_ELEMENTS.
//  - Latency: the result is valid the cycle after the input transfer.
//  - Throughput: one item per cycle unless the output stalls. Active cells
//    compare with the neighbor they point at, the picker selects the largest
//    mobile label, the pair swaps, larger labels flip: one combinational pass.
//  - Stall: the output register holds a result until taken; in_ready stays
//    high while the output is empty or being taken in the same cycle.
//  - Reset (rst_n low, synchronous): identity labels, all left,
//    perm_length=8, no result pending.
`default_nettype none

module sjt_permutation_generator_core #(
  parameter int MAX_ELEMENTS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_restart,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sjt_pkg::SWAP_W-1:0]          out_swap_index,
  output logic [sjt_pkg::LABEL_OUT_W-1:0]     out_moved_label,
  output logic                                out_finished,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sjt_pkg::APB_AW-1:0]          paddr,
  input  logic [sjt_pkg::APB_DW-1:0]          pwdata,
  output logic [sjt_pkg::APB_DW-1:0]          prdata,
  output logic                                pready
);
  import sjt_pkg::*;

  localparam int LW = $clog2(MAX_ELEMENTS + 1);   // label width
  localparam int IW = $clog2(MAX_ELEMENTS);       // position index width
  localparam int CW = (LW > LEN_W) ? LW : LEN_W;  // length compare width

  // ---------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------
  logic [LEN_W-1:0] perm_length_r, perm_length_nxt;
  logic             cfg_wr;
  sjt_reg_t         reg_sel;

  assign reg_sel = sjt_reg_t'(paddr[2]);
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign pready  = 1'b1;

  always_comb begin
    perm_length_nxt = perm_length_r;
    if (cfg_wr && (reg_sel == REG_PERM_LENGTH)) begin
      perm_length_nxt = pwdata[LEN_W-1:0];
    end
  end

  always_comb begin
    case (reg_sel)
      REG_PERM_LENGTH: prdata = APB_DW'(perm_length_r);
      default:         prdata = '0;
    endcase
  end

  // Effective length, clamped to 1..MAX_ELEMENTS
  logic [CW-1:0] len_raw, len_eff;
  always_comb begin
    len_raw = CW'(perm_length_r);
    if (len_raw == '0) begin
      len_eff = CW'(1);
    end else if (len_raw > CW'(MAX_ELEMENTS)) begin
      len_eff = CW'(MAX_ELEMENTS);
    end else begin
      len_eff = len_raw;
    end
  end

  // ---------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------
  logic out_valid_r, out_valid_nxt;
  logic accept, do_load, do_step;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid & in_ready;

  // ---------------------------------------------------------------
  // Row of cells
  // ---------------------------------------------------------------
  logic [LW-1:0]     labels [MAX_ELEMENTS];
  sjt_stat_t         stats  [MAX_ELEMENTS];
  logic [MAX_ELEMENTS-1:0] mobile_vec, hit_vec, active_vec;
  logic              found;
  logic [LW-1:0]     sel_label;

  assign do_load = accept & in_restart;
  assign do_step = accept & !in_restart & found;

  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    logic [LW-1:0] l_label, r_label;
    sjt_stat_t     l_stat, r_stat;
    logic          l_ok, r_ok;

    assign active_vec[i] = (CW'(i) < len_eff);
    assign hit_vec[i]    = stats[i].hit;

    if (i == 0) begin : g_left_edge
      assign l_label = '0;
      assign l_stat  = '0;
      assign l_ok    = 1'b0;
    end else begin : g_left
      assign l_label = labels[i-1];
      assign l_stat  = stats[i-1];
      assign l_ok    = 1'b1;
    end

    if (i == MAX_ELEMENTS - 1) begin : g_right_edge
      assign r_label = '0;
      assign r_stat  = '0;
      assign r_ok    = 1'b0;
    end else begin : g_right
      assign r_label = labels[i+1];
      assign r_stat  = stats[i+1];
      assign r_ok    = active_vec[i+1];
    end

    sjt_cell #(
      .LW  (LW),
      .IDX (i)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .load        (do_load),
      .step        (do_step),
      .active      (active_vec[i]),
      .left_ok     (l_ok),
      .right_ok    (r_ok),
      .left_label  (l_label),
      .right_label (r_label),
      .sel_label   (sel_label),
      .left_stat   (l_stat),
      .right_stat  (r_stat),
      .label       (labels[i]),
      .stat        (stats[i]),
      .mobile      (mobile_vec[i])
    );
  end

  sjt_pick #(
    .N  (MAX_ELEMENTS),
    .LW (LW)
  ) u_pick (
    .labels    (labels),
    .mobile    (mobile_vec),
    .found     (found),
    .sel_label (sel_label)
  );

  // Position of the selected cell and the left end of the swapped pair.
  // sel_label is zero when nothing is mobile, so no cell hits then.
  logic [IW-1:0] pos_idx, left_idx;
  logic          pos_dir;
  always_comb begin
    pos_idx = '0;
    pos_dir = 1'b0;
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      if (hit_vec[i]) begin
        pos_idx = pos_idx | IW'(i);
        pos_dir = pos_dir | stats[i].dir;
      end
    end
    left_idx = pos_dir ? pos_idx : (pos_idx - IW'(1));
  end

  // ---------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------
  logic [SWAP_W-1:0]      out_swap_index_r, out_swap_index_nxt;
  logic [LABEL_OUT_W-1:0] out_moved_label_r, out_moved_label_nxt;
  logic                   out_finished_r, out_finished_nxt;

  always_comb begin
    out_valid_nxt       = out_valid_r;
    out_swap_index_nxt  = out_swap_index_r;
    out_moved_label_nxt = out_moved_label_r;
    out_finished_nxt    = out_finished_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt       = 1'b1;
      out_swap_index_nxt  = '0;
      out_moved_label_nxt = '0;
      out_finished_nxt    = 1'b0;
      if (!in_restart) begin
        if (found) begin
          out_swap_index_nxt  = SWAP_W'(left_idx);
          out_moved_label_nxt = LABEL_OUT_W'(sel_label);
        end else begin
          out_finished_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      perm_length_r <= PERM_LENGTH_RST;
    end else begin
      out_valid_r   <= out_valid_nxt;
      perm_length_r <= perm_length_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_swap_index_r  <= out_swap_index_nxt;
    out_moved_label_r <= out_moved_label_nxt;
    out_finished_r    <= out_finished_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_swap_index  = out_swap_index_r;
  assign out_moved_label = out_moved_label_r;
  assign out_finished    = out_finished_r;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  // labels are distinct, so exactly one cell holds the selected label
  a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
    found |-> $onehot(hit_vec))
    else $error("selected label not held by exactly one cell");

  a_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    !found |-> (hit_vec == '0))
    else $error("cell hit without a mobile label");

  a_step_label: assert property (@(posedge clk) disable iff (!rst_n)
    do_step |=> out_valid_r && !out_finished_r
                && (out_moved_label_r == $past(LABEL_OUT_W'(sel_label))))
    else $error("moved label does not match selected label");

  a_finished_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_finished_r) |->
      (out_swap_index_r == '0) && (out_moved_label_r == '0))
    else $error("finished result carries a nonzero swap");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    do_load |=> (labels[0] == LW'(1)) && !stats[0].dir)
    else $error("restart did not reload the first cell");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sjt_permutation_generator_core.
// Depends on sjt_pkg and the core RTL; drives both channels and the APB port.

module tb;
  import sjt_pkg::*;

  localparam int NUM_CELLS       = 8;     // built MAX_ELEMENTS of the dut
  localparam int STALL_LIMIT     = 2000;  // cycles without any transfer
  localparam int ITEMS_PER_PHASE = 112;
  localparam int NUM_PHASES      = 12;

  // One result of the generator, as seen on the out_ ports
  typedef struct packed {
    logic [SWAP_W-1:0]      swap_index;
    logic [LABEL_OUT_W-1:0] moved_label;
    logic                   finished;
  } move_t;

  // Directed row: optional length write before the item, then the item.
  // When typed is set the expected move is taken from the row itself.
  typedef struct packed {
    logic                   do_cfg;
    logic [LEN_W-1:0]       len;
    logic                   restart;
    logic                   typed;
    logic [SWAP_W-1:0]      swap_index;
    logic [LABEL_OUT_W-1:0] moved_label;
    logic                   finished;
  } dir_row_t;

  localparam int NUM_ROWS = 23;
  localparam dir_row_t DIRECTED [NUM_ROWS] = '{
    // straight out of reset: length 8, identity, 8 walks left
    '{1'b0, 4'd0,  1'b0, 1'b1, 3'd6, 4'd8, 1'b0},
    '{1'b0, 4'd0,  1'b0, 1'b1, 3'd5, 4'd8, 1'b0},
    '{1'b0, 4'd0,  1'b1, 1'b1, 3'd0, 4'd0, 1'b0},
    '{1'b0, 4'd0,  1'b0, 1'b1, 3'd6, 4'd8, 1'b0},
    '{1'b0, 4'd0,  1'b0, 1'b0, 3'd0, 4'd0, 1'b0},
    '{1'b0, 4'd0,  1'b0, 1'b0, 3'd0, 4'd0, 1'b0},
    '{1'b0, 4'd0,  1'b0, 1'b0, 3'd0, 4'd0, 1'b0},
    '{1'b0, 4'd0,  1'b0, 1'b0, 3'd0, 4'd0, 1'b0},
    // single position: nothing is ever mobile
    '{1'b1, 4'd1,  1'b0, 1'b1, 3'd0, 4'd0, 1'b1},
    '{1'b0, 4'd0,  1'b0, 1'b1, 3'd0, 4'd0, 1'b1},
    // zero length behaves as one
    '{1'b1, 4'd0,  1'b0, 1'b1, 3'd0, 4'd0, 1'b1},
    // two positions: one swap, then finished and it stays finished
    '{1'b1, 4'd2,  1'b1, 1'b1, 3'd0, 4'd0, 1'b0},
    '{1'b0, 4'd0,  1'b0, 1'b1, 3'd0, 4'd2, 1'b0},
    '{1'b0, 4'd0,  1'b0, 1'b1, 3'd0, 4'd0, 1'b1},
    '{1'b0, 4'd0,  1'b0, 1'b1, 3'd0, 4'd0, 1'b1},
    // grow the length without restart: stores are used as they stand
    '{1'b1, 4'd3,  1'b0, 1'b0, 3'd0, 4'd0, 1'b0},
    '{1'b0, 4'd0,  1'b0, 1'b0, 3'd0, 4'd0, 1'b0},
    // oversize length clamps to the full row
    '{1'b1, 4'd15, 1'b0, 1'b0, 3'd0, 4'd0, 1'b0},
    '{1'b0, 4'd0,  1'b1, 1'b1, 3'd0, 4'd0, 1'b0},
    '{1'b0, 4'd0,  1'b0, 1'b1, 3'd6, 4'd8, 1'b0},
    '{1'b1, 4'd9,  1'b0, 1'b0, 3'd0, 4'd0, 1'b0},
    '{1'b0, 4'd0,  1'b0, 1'b0, 3'd0, 4'd0, 1'b0},
    '{1'b1, 4'd8,  1'b1, 1'b1, 3'd0, 4'd0, 1'b0}
  };

  // Length setting of each random phase; 0 and 15 are the extremes
  localparam logic [LEN_W-1:0] PHASE_LEN [NUM_PHASES] = '{
    4'd3, 4'd0, 4'd4, 4'd8, 4'd2, 4'd15, 4'd5, 4'd1, 4'd6, 4'd9, 4'd7, 4'd4
  };

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  // ---------------------------------------------------------------------------
  // DUT signals; every input holds a known value from time zero
  // ---------------------------------------------------------------------------
  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_valid   = 1'b0;
  logic                   in_restart = 1'b0;
  logic                   out_ready  = 1'b0;
  logic                   psel       = 1'b0;
  logic                   penable    = 1'b0;
  logic                   pwrite     = 1'b0;
  logic [APB_AW-1:0]      paddr      = '0;
  logic [APB_DW-1:0]      pwdata     = '0;
  logic                   in_ready;
  logic                   out_valid;
  logic [SWAP_W-1:0]      out_swap_index;
  logic [LABEL_OUT_W-1:0] out_moved_label;
  logic                   out_finished;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;

  sjt_permutation_generator_core #(
    .MAX_ELEMENTS(NUM_CELLS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_swap_index (out_swap_index),
    .out_moved_label(out_moved_label),
    .out_finished   (out_finished),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the generator: labels, directions (0 = left) and length
  // ---------------------------------------------------------------------------
  logic [LABEL_OUT_W-1:0] shadow_label [NUM_CELLS];
  logic                   shadow_dir   [NUM_CELLS];
  logic [LEN_W-1:0]       shadow_len;

  move_t pending_moves [$];   // expected moves, oldest first
  int    fail_count     = 0;
  int    send_idle_pct  = 0;  // chance per cycle that the sender idles
  int    recv_stall_pct = 0;  // chance per cycle that the receiver stalls
  int    quiet_cycles   = 0;

  task automatic load_identity();
    for (int i = 0; i < NUM_CELLS; i++) begin
      shadow_label[i] = LABEL_OUT_W'(i + 1);
      shadow_dir[i]   = 1'b0;
    end
  endtask

  // Active length after clamping: 0 acts as 1, oversize as the full row
  function automatic int active_len();
    if (shadow_len == '0) return 1;
    if (int'(shadow_len) > NUM_CELLS) return NUM_CELLS;
    return int'(shadow_len);
  endfunction

  // Apply one transfer to the shadow state and return the move it yields
  task automatic sjt_next_move(input logic restart, output move_t mv);
    int                     n;
    int                     best;
    int                     nb;
    logic [LABEL_OUT_W-1:0] best_label;
    logic [LABEL_OUT_W-1:0] tmp_label;
    logic                   tmp_dir;
    mv = '0;
    n  = active_len();
    if (restart) begin
      load_identity();
    end else begin
      // largest label that is bigger than the neighbor it points at
      best       = -1;
      best_label = '0;
      for (int i = 0; i < n; i++) begin
        nb = shadow_dir[i] ? i + 1 : i - 1;
        if (nb >= 0 && nb < n) begin
          if (shadow_label[i] > shadow_label[nb] && shadow_label[i] > best_label) begin
            best_label = shadow_label[i];
            best       = i;
          end
        end
      end
      if (best < 0) begin
        mv.finished = 1'b1;   // state left as it is
      end else begin
        nb = shadow_dir[best] ? best + 1 : best - 1;
        // label travels with its direction bit
        tmp_label          = shadow_label[best];
        shadow_label[best] = shadow_label[nb];
        shadow_label[nb]   = tmp_label;
        tmp_dir            = shadow_dir[best];
        shadow_dir[best]   = shadow_dir[nb];
        shadow_dir[nb]     = tmp_dir;
        for (int i = 0; i < n; i++)
          if (shadow_label[i] > best_label) shadow_dir[i] = ~shadow_dir[i];
        mv.swap_index  = SWAP_W'(best < nb ? best : nb);
        mv.moved_label = best_label;
      end
    end
  endtask

  function automatic void report_mismatch(string what, int want, int got);
    fail_count++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers. Each starts and ends just after a falling edge, so no
  // input is assigned twice in one time step.
  // ---------------------------------------------------------------------------

  // One input transfer, preceded by random sender idling
  task automatic send_item(input logic restart, input logic typed, input move_t want);
    move_t mv;
    while (int'($urandom_range(0, 99)) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
    // transfer taken at this edge: advance the shadow state
    sjt_next_move(restart, mv);
    pending_moves.push_back(typed ? want : mv);
    @(negedge clk);
  endtask

  // Drain: no transfer in flight and every expected move has come back.
  // Every item yields a move, so the queue shows what is still in flight.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_moves.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // APB write of perm_length followed by a readback; psel stays high
  // between the two so it is never lowered and raised in one step.
  task automatic write_length(input logic [LEN_W-1:0] len);
    logic [APB_DW-1:0] wdata;
    wdata             = APB_DW'($urandom);   // upper bits are don't-care
    wdata[LEN_W-1:0]  = len;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(4 * int'(REG_PERM_LENGTH));
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    shadow_len = wdata[LEN_W-1:0];
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== APB_DW'(shadow_len))
      report_mismatch("perm_length readback", int'(shadow_len), int'(prdata));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_idle_mode(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 74; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 74; end
      default:   begin send_idle_pct = 16; recv_stall_pct = 16; end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: out_ready changes on the falling edge only
  // ---------------------------------------------------------------------------
  always @(negedge clk)
    out_ready <= (int'($urandom_range(0, 99)) >= recv_stall_pct);

  // ---------------------------------------------------------------------------
  // Result checker: every out_ transfer against the oldest expected move
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    move_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_moves.size() == 0) begin
        fail_count++;
        $display("%0t: result transfer mismatch, expected none, actual %0d/%0d/%0d",
                 $time, out_swap_index, out_moved_label, out_finished);
      end else begin
        want = pending_moves.pop_front();
        if (out_swap_index !== want.swap_index)
          report_mismatch("swap_index", int'(want.swap_index), int'(out_swap_index));
        if (out_moved_label !== want.moved_label)
          report_mismatch("moved_label", int'(want.moved_label), int'(out_moved_label));
        if (out_finished !== want.finished)
          report_mismatch("finished", int'(want.finished), int'(out_finished));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too many cycles in a row without any transfer ends the run
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[sjt_permutation_generator_core] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, random phases, drain, verdict
  // ---------------------------------------------------------------------------
  initial begin
    int    n;
    int    span;
    logic  restart;
    move_t want;

    // shadow state after reset: identity, all left, length 8
    load_identity();
    shadow_len = PERM_LENGTH_RST;
    set_idle_mode(IDLE_NONE);

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part: extremes, length clamping, finished, mid-run changes
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (DIRECTED[r].do_cfg) begin
        wait_drained();
        write_length(DIRECTED[r].len);
      end
      want.swap_index  = DIRECTED[r].swap_index;
      want.moved_label = DIRECTED[r].moved_label;
      want.finished    = DIRECTED[r].finished;
      send_item(DIRECTED[r].restart, DIRECTED[r].typed, want);
    end

    // random part: mostly long advance runs, so short lengths reach the
    // finished state; the rest is restart noise
    want = '0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      write_length(PHASE_LEN[p]);
      set_idle_mode(idle_mode_t'(p % 4));
      // sometimes keep the old arrangement across the length change
      if ($urandom_range(0, 2) != 0) send_item(1'b1, 1'b0, want);
      n    = active_len();
      span = 1;
      for (int k = 2; k <= n && span < 200; k++) span = span * k;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ($urandom_range(0, 99) < 85)
          restart = ($urandom_range(0, 2 * span - 1) == 0);
        else
          restart = 1'($urandom_range(0, 1));
        send_item(restart, 1'b0, want);
      end
    end

    wait_drained();
    repeat (4) @(negedge clk);

    if (fail_count == 0)
      $display("[sjt_permutation_generator_core] OK");
    else
      $display("[sjt_permutation_generator_core] ERROR");
    $finish;
  end

endmodule
